[src/lmfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_pkg
// Shared types and constants for the LED matrix frame scaler.
// ----------------------------------------------------------------------------
package lmfs_pkg;

  localparam int unsigned SIDE = 8;
  localparam int unsigned NPIX = SIDE * SIDE;
  localparam int unsigned AW   = $clog2(NPIX);
  localparam int unsigned CW   = $clog2(SIDE);
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    MODE_WRITE = 3'd0,
    MODE_READ  = 3'd1,
    MODE_FILL  = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_MONO  = 3'd4,
    MODE_SHOW  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_ROTATION   = 2'd1,
    REG_MAX_CURR   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] x;
    logic [3:0] y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] off_red;
    logic [7:0] off_green;
    logic [7:0] off_blue;
    logic [7:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic       is_read;
    logic [5:0] led_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_READ, ST_RDWAIT, ST_SUM, ST_SUMEND,
    ST_EST, ST_RECIP, ST_DIV, ST_SCALE, ST_EMIT, ST_EMUL, ST_EMIT_OUT
  } back_state_t;

endpackage

[src/lmfs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_in_if / lmfs_out_if
// Valid/ready channels carrying input requests and result items.
// ----------------------------------------------------------------------------
interface lmfs_in_if;
  logic               valid;
  logic               ready;
  lmfs_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lmfs_out_if;
  logic                valid;
  logic                ready;
  lmfs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/lmfs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmfs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/lmfs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_front
// Accepts requests, drops those without effect, queues the rest.
// ----------------------------------------------------------------------------
module lmfs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmfs_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output lmfs_pkg::in_item_t q_data
);
  localparam int unsigned PW = $clog2(lmfs_pkg::QDEPTH);

  lmfs_pkg::in_item_t slot [lmfs_pkg::QDEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;
  logic          push, pop, useful;

  // Unused modes and out-of-range writes/rows are swallowed here.
  always_comb begin
    case (in_data.mode)
      lmfs_pkg::MODE_WRITE: useful = (in_data.x < lmfs_pkg::SIDE) &&
                                     (in_data.y < lmfs_pkg::SIDE);
      lmfs_pkg::MODE_MONO:  useful = in_data.y < lmfs_pkg::SIDE;
      lmfs_pkg::MODE_READ, lmfs_pkg::MODE_FILL,
      lmfs_pkg::MODE_CLEAR, lmfs_pkg::MODE_SHOW: useful = 1'b1;
      default: useful = 1'b0;
    endcase
  end

  assign in_ready = count != (PW+1)'(lmfs_pkg::QDEPTH);
  assign push     = in_valid && in_ready && useful;
  assign q_valid  = count != '0;
  assign pop      = q_valid && q_ready;
  assign q_data   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_data;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule

[src/lmfs_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmfs_back
// Executes queued requests against the frame store; computes show scale.
// ----------------------------------------------------------------------------
module lmfs_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  lmfs_pkg::in_item_t  q_data,
  input  logic [7:0]          brightness,
  input  logic [1:0]          rotation,
  input  logic [11:0]         max_current_ma,
  output logic                out_valid,
  input  logic                out_ready,
  output lmfs_pkg::out_item_t out_data
);
  localparam int unsigned AW = lmfs_pkg::AW;
  localparam int unsigned CW = lmfs_pkg::CW;
  localparam int unsigned SW = AW + 10;       // frame component sum
  localparam int unsigned EW = SW + 13;       // sum*20*brightness
  localparam int unsigned NW = 20;            // brightness*max_current
  // Divide by 65025 as (p * RECIP) >> RS, exact for p below 2^28.
  localparam int unsigned RS = 44;
  localparam logic [EW-1:0] RECIP = EW'(270544961);

  lmfs_pkg::back_state_t state, state_next;
  lmfs_pkg::in_item_t    cur;
  logic [AW:0]           idx, idx_next;
  logic [SW-1:0]         sum;
  logic [EW-1:0]         prod;
  logic [EW-1:0]         est;
  logic [NW-1:0]         num, quo;
  logic [EW-1:0]         rem;
  logic [4:0]            bitn;
  logic [7:0]            scale;
  logic [15:0]           mr, mg, mb;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [23:0]   wdata, rdata;

  lmfs_ram #(.WIDTH(24), .DEPTH(lmfs_pkg::NPIX)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Output register
  logic      ov;
  logic      load;
  lmfs_pkg::out_item_t od, od_new;
  assign out_valid = ov;
  assign out_data  = od;

  logic [CW-1:0] px, py, rx, ry, colx;
  logic [AW-1:0] led;
  logic [2:0]    bsel;
  logic          on_bit;

  assign px = idx[CW-1:0];
  assign py = idx[AW-1:CW];

  always_comb begin
    case (rotation)
      2'd1:    begin rx = ~py; ry = px;  end
      2'd2:    begin rx = ~px; ry = ~py; end
      2'd3:    begin rx = py;  ry = ~px; end
      default: begin rx = px;  ry = py;  end
    endcase
    colx = ry[0] ? ~rx : rx;
    led  = {ry, colx};
  end

  // Mono bit for column px: bit SIDE-1-px, off when beyond the bitmap.
  always_comb begin
    bsel   = 3'(lmfs_pkg::SIDE - 1 - 32'(px));
    on_bit = ((lmfs_pkg::SIDE - 1 - 32'(px)) < 8) && cur.row_bits[bsel];
  end

  // Divide by 255 for values up to 255*255: q = (v + 1 + (v >> 8)) >> 8.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

  always_comb begin
    state_next = state;
    idx_next   = idx;
    q_ready    = 1'b0;
    we         = 1'b0;
    waddr      = idx[AW-1:0];
    wdata      = '0;
    raddr      = idx[AW-1:0];
    load       = 1'b0;
    od_new     = '0;
    case (state)
      lmfs_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_ready  = 1'b1;
          idx_next = '0;
          case (q_data.mode)
            lmfs_pkg::MODE_WRITE: begin
              we         = 1'b1;
              waddr      = {q_data.y[CW-1:0], q_data.x[CW-1:0]};
              wdata      = {q_data.red, q_data.green, q_data.blue};
            end
            lmfs_pkg::MODE_READ:  state_next = lmfs_pkg::ST_READ;
            lmfs_pkg::MODE_MONO:  idx_next = {1'b0, q_data.y[CW-1:0], {CW{1'b0}}};
            lmfs_pkg::MODE_SHOW:  state_next = lmfs_pkg::ST_SUM;
            default: ;
          endcase
          if (q_data.mode == lmfs_pkg::MODE_FILL || q_data.mode == lmfs_pkg::MODE_CLEAR ||
              q_data.mode == lmfs_pkg::MODE_MONO) begin
            state_next = lmfs_pkg::ST_SWEEP;
          end
        end
      end
      lmfs_pkg::ST_SWEEP: begin
        we = 1'b1;
        case (cur.mode)
          lmfs_pkg::MODE_FILL: wdata = {cur.red, cur.green, cur.blue};
          lmfs_pkg::MODE_MONO: wdata = on_bit ? {cur.red, cur.green, cur.blue}
                                              : {cur.off_red, cur.off_green, cur.off_blue};
          default: wdata = '0;
        endcase
        idx_next = idx + 1'b1;
        if ((cur.mode == lmfs_pkg::MODE_MONO && px == CW'(lmfs_pkg::SIDE - 1)) ||
            idx == (AW+1)'(lmfs_pkg::NPIX - 1)) begin
          state_next = lmfs_pkg::ST_IDLE;
        end
      end
      lmfs_pkg::ST_READ: begin
        raddr      = {cur.y[CW-1:0], cur.x[CW-1:0]};
        state_next = lmfs_pkg::ST_RDWAIT;
      end
      lmfs_pkg::ST_RDWAIT: begin
        // keep the address so the read data holds while the output stalls
        raddr = {cur.y[CW-1:0], cur.x[CW-1:0]};
        if (!ov || out_ready) begin
          load           = 1'b1;
          od_new.is_read = 1'b1;
          od_new.last    = 1'b1;
          if (cur.x < lmfs_pkg::SIDE && cur.y < lmfs_pkg::SIDE) begin
            {od_new.out_red, od_new.out_green, od_new.out_blue} = rdata;
          end
          state_next = lmfs_pkg::ST_IDLE;
        end
      end
      lmfs_pkg::ST_SUM: begin
        // the read address leads accumulation; the sum adds the registered read data
        idx_next = idx + 1'b1;
        if (idx == (AW+1)'(lmfs_pkg::NPIX - 1)) state_next = lmfs_pkg::ST_SUMEND;
      end
      lmfs_pkg::ST_SUMEND: state_next = lmfs_pkg::ST_EST;
      lmfs_pkg::ST_EST:    state_next = lmfs_pkg::ST_RECIP;
      lmfs_pkg::ST_RECIP:  state_next = lmfs_pkg::ST_DIV;
      lmfs_pkg::ST_DIV: begin
        if (bitn == 5'd0) state_next = lmfs_pkg::ST_SCALE;
      end
      lmfs_pkg::ST_SCALE: begin
        idx_next   = '0;
        state_next = lmfs_pkg::ST_EMIT;
      end
      lmfs_pkg::ST_EMIT:   state_next = lmfs_pkg::ST_EMUL;
      lmfs_pkg::ST_EMUL:   state_next = lmfs_pkg::ST_EMIT_OUT;
      lmfs_pkg::ST_EMIT_OUT: begin
        if (!ov || out_ready) begin
          load             = 1'b1;
          od_new.led_index = 6'(led);
          od_new.out_red   = div255(mr);
          od_new.out_green = div255(mg);
          od_new.out_blue  = div255(mb);
          od_new.last      = idx == (AW+1)'(lmfs_pkg::NPIX - 1);
          idx_next         = idx + 1'b1;
          state_next       = od_new.last ? lmfs_pkg::ST_IDLE : lmfs_pkg::ST_EMIT;
        end
      end
      default: state_next = lmfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == lmfs_pkg::ST_IDLE && q_valid) cur <= q_data;
    if (load) od <= od_new;
    if (state == lmfs_pkg::ST_IDLE) sum <= '0;
    if ((state == lmfs_pkg::ST_SUM && idx != '0) || state == lmfs_pkg::ST_SUMEND) begin
      sum <= sum + SW'(rdata[23:16]) + SW'(rdata[15:8]) + SW'(rdata[7:0]);
    end
    if (state == lmfs_pkg::ST_EST) begin
      prod <= EW'(sum) * EW'(brightness) * EW'(20);
      num  <= NW'(brightness) * NW'(max_current_ma);
      rem  <= '0;
      bitn <= 5'(NW);
    end
    if (state == lmfs_pkg::ST_RECIP) begin
      est <= EW'(((2*EW)'(prod) * (2*EW)'(RECIP)) >> RS);
    end
    if (state == lmfs_pkg::ST_DIV && bitn != 5'd0) begin
      // restoring division, one quotient bit per cycle
      if ({rem[EW-2:0], num[NW-1]} >= est) begin
        rem <= {rem[EW-2:0], num[NW-1]} - est;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[EW-2:0], num[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
      num  <= {num[NW-2:0], 1'b0};
      bitn <= bitn - 5'd1;
    end
    if (state == lmfs_pkg::ST_SCALE) begin
      if (est <= EW'(max_current_ma)) scale <= brightness;
      else if (quo > NW'(255))        scale <= 8'd255;
      else                            scale <= quo[7:0];
    end
    if (state == lmfs_pkg::ST_EMUL) begin
      mr <= 16'(rdata[23:16]) * 16'(scale);
      mg <= 16'(rdata[15:8])  * 16'(scale);
      mb <= 16'(rdata[7:0])   * 16'(scale);
    end
    if (rst) begin
      state <= lmfs_pkg::ST_IDLE;
      idx   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (load)           ov <= 1'b1;
      else if (out_ready) ov <= 1'b0;
    end
  end
endmodule

[src/led_matrix_frame_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_frame_scaler
// 8x8 RGB frame store with current-limited, rotated serpentine show output.
// ----------------------------------------------------------------------------
// A pixel write is done as the back end takes it from the queue; a read
// passes through the READ and RDWAIT states, waiting there for the output.
// Fill and clear sweep the store one pixel a cycle, a mono row likewise.
// Show sums the frame through the single RAM read port, forms the current
// estimate (EST, RECIP), finds the scale by bit-serial division, then emits
// each pixel through EMIT (read), EMUL (multiply) and EMIT_OUT (output),
// starting the next pixel only once the last is in the output register.
// Requests that have no effect are dropped at the front; a two-entry queue
// lets the front keep accepting while the back end works, until it fills.
// Reset clears the store by a sweep before the first queued request runs.
// ----------------------------------------------------------------------------
module led_matrix_frame_scaler (
  input  logic        clk,
  input  logic        rst,
  lmfs_in_if.sink     in_ch,
  lmfs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0]  brightness;
  logic [1:0]  rotation;
  logic [11:0] max_current_ma;
  lmfs_pkg::reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = lmfs_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness     <= 8'd64;
      rotation       <= 2'd0;
      max_current_ma <= 12'd500;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (ridx)
        lmfs_pkg::REG_BRIGHTNESS: brightness     <= pwdata[7:0];
        lmfs_pkg::REG_ROTATION:   rotation       <= pwdata[1:0];
        lmfs_pkg::REG_MAX_CURR:   max_current_ma <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      lmfs_pkg::REG_BRIGHTNESS: prdata = {24'd0, brightness};
      lmfs_pkg::REG_ROTATION:   prdata = {30'd0, rotation};
      lmfs_pkg::REG_MAX_CURR:   prdata = {20'd0, max_current_ma};
      default:                  prdata = '0;
    endcase
  end

  // Reset clears the store by queuing an internal clear request.
  logic               boot;
  logic               f_valid, f_ready, q_valid, q_ready;
  lmfs_pkg::in_item_t f_data, q_data;

  always_ff @(posedge clk) begin
    if (rst) boot <= 1'b1;
    else if (f_ready) boot <= 1'b0;
  end

  always_comb begin
    f_data = in_ch.data;
    if (boot) f_data.mode = 3'(lmfs_pkg::MODE_CLEAR);
  end
  assign f_valid     = boot || in_ch.valid;
  assign in_ch.ready = f_ready && !boot;

  lmfs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
  );

  lmfs_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .brightness(brightness), .rotation(rotation), .max_current_ma(max_current_ma),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

[dv/tb_led_matrix_frame_scaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_matrix_frame_scaler
// Self-checking bench for the LED matrix frame scaler.
// ----------------------------------------------------------------------------
// Requests go in on the valid/ready input channel. A local frame model with
// its own copy of the registers predicts every read reply and shown pixel,
// and each accepted result is checked field by field against the oldest
// prediction. The run has a directed table (extremes, all modes, the
// out-of-range cases, a hand-checked read after reset), then random traffic
// in three idling phases with register changes between phases. One stretch
// holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_led_matrix_frame_scaler;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lmfs_in_if  in_ch ();
  lmfs_out_if out_ch ();

  led_matrix_frame_scaler dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Local frame model and register copies.
  logic [23:0] pix_mem [lmfs_pkg::NPIX];
  logic [7:0]  cur_bright;
  logic [1:0]  cur_rot;
  logic [11:0] cur_limit;

  lmfs_pkg::out_item_t pending_px [$];
  int          mismatch_cnt;
  int          req_cnt, shown_cnt, read_cnt;

  // Idling knobs: idle rates in percent and a receiver hold-off in cycles.
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hard ceiling: with about 360 requests, stalls, and phase pauses this
  // leaves a wide margin.
  initial begin
    #20ms;
    $display("[led_matrix_frame_scaler] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (at %0t)", what, got, want, $time);
    mismatch_cnt++;
  endtask

  function automatic logic [5:0] led_slot(input int col, input int row);
    int rx, ry;
    case (cur_rot)
      2'd1: begin rx = lmfs_pkg::SIDE - 1 - row; ry = col; end
      2'd2: begin rx = lmfs_pkg::SIDE - 1 - col; ry = lmfs_pkg::SIDE - 1 - row; end
      2'd3: begin rx = row; ry = lmfs_pkg::SIDE - 1 - col; end
      default: begin rx = col; ry = row; end
    endcase
    return 6'(ry * lmfs_pkg::SIDE + ((ry % 2) ? (lmfs_pkg::SIDE - 1 - rx) : rx));
  endfunction

  function automatic int show_scale();
    longint total, est, lim;
    total = 0;
    for (int k = 0; k < lmfs_pkg::NPIX; k++)
      total += pix_mem[k][23:16] + pix_mem[k][15:8] + pix_mem[k][7:0];
    est = (total * 20 * cur_bright) / 65025;
    if (est <= cur_limit) return cur_bright;
    lim = (longint'(cur_bright) * cur_limit) / est;
    return (lim > 255) ? 255 : int'(lim);
  endfunction

  // Apply one accepted request to the model and queue what it must produce.
  task automatic predict_request(input lmfs_pkg::in_item_t rq);
    lmfs_pkg::out_item_t o;
    int sc;
    logic [23:0] on_c, off_c;
    on_c  = {rq.red, rq.green, rq.blue};
    off_c = {rq.off_red, rq.off_green, rq.off_blue};
    case (rq.mode)
      lmfs_pkg::MODE_WRITE:
        if (rq.x < lmfs_pkg::SIDE && rq.y < lmfs_pkg::SIDE)
          pix_mem[rq.y * lmfs_pkg::SIDE + rq.x] = on_c;
      lmfs_pkg::MODE_READ: begin
        o = '0;
        o.is_read = 1'b1;
        o.last    = 1'b1;
        if (rq.x < lmfs_pkg::SIDE && rq.y < lmfs_pkg::SIDE)
          {o.out_red, o.out_green, o.out_blue} = pix_mem[rq.y * lmfs_pkg::SIDE + rq.x];
        pending_px.push_back(o);
      end
      lmfs_pkg::MODE_FILL:  for (int k = 0; k < lmfs_pkg::NPIX; k++) pix_mem[k] = on_c;
      lmfs_pkg::MODE_CLEAR: for (int k = 0; k < lmfs_pkg::NPIX; k++) pix_mem[k] = '0;
      lmfs_pkg::MODE_MONO: if (rq.y < lmfs_pkg::SIDE) begin
        for (int c = 0; c < lmfs_pkg::SIDE; c++)
          pix_mem[rq.y * lmfs_pkg::SIDE + c] =
            rq.row_bits[lmfs_pkg::SIDE - 1 - c] ? on_c : off_c;
      end
      lmfs_pkg::MODE_SHOW: begin
        sc = show_scale();
        for (int k = 0; k < lmfs_pkg::NPIX; k++) begin
          o.is_read   = 1'b0;
          o.led_index = led_slot(k % lmfs_pkg::SIDE, k / lmfs_pkg::SIDE);
          o.out_red   = 8'(pix_mem[k][23:16] * sc / 255);
          o.out_green = 8'(pix_mem[k][15:8] * sc / 255);
          o.out_blue  = 8'(pix_mem[k][7:0] * sc / 255);
          o.last      = (k == lmfs_pkg::NPIX - 1);
          pending_px.push_back(o);
        end
      end
      default: ;  // unused modes do nothing
    endcase
  endtask

  // Input monitor: predictions are made in acceptance order.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_request(in_ch.data);
      req_cnt++;
    end
  end

  // Output checker.
  always @(posedge clk) begin
    lmfs_pkg::out_item_t g, w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (pending_px.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_px.pop_front();
        if (g.is_read !== w.is_read)     report_mismatch("is_read", g.is_read, w.is_read);
        if (g.led_index !== w.led_index) report_mismatch("led_index", g.led_index, w.led_index);
        if (g.out_red !== w.out_red)     report_mismatch("out_red", g.out_red, w.out_red);
        if (g.out_green !== w.out_green) report_mismatch("out_green", g.out_green, w.out_green);
        if (g.out_blue !== w.out_blue)   report_mismatch("out_blue", g.out_blue, w.out_blue);
        if (g.last !== w.last)           report_mismatch("last", g.last, w.last);
        if (w.is_read) read_cnt++; else shown_cnt++;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Register write through the config port: setup, then access.
  task automatic write_reg(input lmfs_pkg::reg_idx_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lmfs_pkg::REG_BRIGHTNESS: cur_bright = val[7:0];
      lmfs_pkg::REG_ROTATION:   cur_rot    = val[1:0];
      default:                  cur_limit  = val[11:0];
    endcase
  endtask

  // Offer one request; a gap may come first, then valid holds until accepted.
  task automatic send_request(input lmfs_pkg::in_item_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Wait for all predictions to drain, then let write/fill work settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic lmfs_pkg::in_item_t random_request();
    lmfs_pkg::in_item_t rq;
    int pick;
    rq = ($bits(lmfs_pkg::in_item_t))'({$urandom, $urandom, $urandom});
    pick = $urandom_range(99);
    // Mostly in-range writes and reads, with some fills, clears, rows, shows and unused modes.
    if (pick < 40)      rq.mode = lmfs_pkg::MODE_WRITE;
    else if (pick < 62) rq.mode = lmfs_pkg::MODE_READ;
    else if (pick < 68) rq.mode = lmfs_pkg::MODE_FILL;
    else if (pick < 71) rq.mode = lmfs_pkg::MODE_CLEAR;
    else if (pick < 82) rq.mode = lmfs_pkg::MODE_MONO;
    else if (pick < 89) rq.mode = lmfs_pkg::MODE_SHOW;
    else if (pick < 92) rq.mode = 3'($urandom_range(6, 7));
    if ($urandom_range(9) < 8) begin
      rq.x = 4'($urandom_range(lmfs_pkg::SIDE - 1));
      rq.y = 4'($urandom_range(lmfs_pkg::SIDE - 1));
    end
    return rq;
  endfunction

  typedef struct {
    logic [2:0] mode;
    logic [3:0] x, y;
    logic [23:0] on_c, off_c;
    logic [7:0] bits;
  } stim_row_t;

  stim_row_t dir_tab [] = '{
    '{lmfs_pkg::MODE_READ,  4'd0,  4'd0,  24'h0,      24'h0,      8'h00}, // black after reset
    '{lmfs_pkg::MODE_SHOW,  4'd0,  4'd0,  24'h0,      24'h0,      8'h00}, // zero estimate
    '{lmfs_pkg::MODE_WRITE, 4'd7,  4'd7,  24'hFFFFFF, 24'h0,      8'h00},
    '{lmfs_pkg::MODE_READ,  4'd7,  4'd7,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_WRITE, 4'd8,  4'd0,  24'h123456, 24'h0,      8'h00}, // write past edge
    '{lmfs_pkg::MODE_WRITE, 4'd0,  4'd15, 24'h654321, 24'h0,      8'h00},
    '{lmfs_pkg::MODE_READ,  4'd15, 4'd15, 24'h0,      24'h0,      8'h00}, // read past edge
    '{lmfs_pkg::MODE_READ,  4'd8,  4'd0,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_MONO,  4'd0,  4'd3,  24'hFF00FF, 24'h00FF00, 8'hA5},
    '{lmfs_pkg::MODE_MONO,  4'd0,  4'd9,  24'hFFFFFF, 24'hFFFFFF, 8'hFF}, // row past edge
    '{lmfs_pkg::MODE_READ,  4'd0,  4'd3,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_READ,  4'd1,  4'd3,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_SHOW,  4'd0,  4'd0,  24'h0,      24'h0,      8'h00},
    '{3'd6,                 4'd1,  4'd1,  24'hFFFFFF, 24'h0,      8'h00}, // unused modes
    '{3'd7,                 4'd2,  4'd2,  24'hFFFFFF, 24'h0,      8'h00},
    '{lmfs_pkg::MODE_FILL,  4'd0,  4'd0,  24'hFFFFFF, 24'h0,      8'h00}, // full white
    '{lmfs_pkg::MODE_SHOW,  4'd0,  4'd0,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_READ,  4'd4,  4'd4,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_CLEAR, 4'd0,  4'd0,  24'h0,      24'h0,      8'h00},
    '{lmfs_pkg::MODE_READ,  4'd7,  4'd7,  24'h0,      24'h0,      8'h00}
  };

  // Expected read replies where they are plain: index into dir_tab, color.
  int          known_row [4] = '{0, 3, 6, 19};
  logic [23:0] known_col [4] = '{24'h0, 24'hFFFFFF, 24'h0, 24'h0};

  initial begin
    lmfs_pkg::in_item_t rq;
    automatic int hits;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    mismatch_cnt = 0; req_cnt = 0; shown_cnt = 0; read_cnt = 0;
    hold_cycles = 0;
    send_idle_pct = 18;
    recv_idle_pct = 46;
    cur_bright = 8'd64; cur_rot = 2'd0; cur_limit = 12'd500;
    for (int k = 0; k < lmfs_pkg::NPIX; k++) pix_mem[k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int r = 0; r < dir_tab.size(); r++) begin
      rq = '0;
      rq.mode = dir_tab[r].mode;
      rq.x = dir_tab[r].x;
      rq.y = dir_tab[r].y;
      {rq.red, rq.green, rq.blue} = dir_tab[r].on_c;
      {rq.off_red, rq.off_green, rq.off_blue} = dir_tab[r].off_c;
      rq.row_bits = dir_tab[r].bits;
      // Cross-check hand-typed read replies against what the model queues.
      for (int j = 0; j < 4; j++) begin
        if (known_row[j] == r) begin
          send_request(rq);
          in_ch.valid <= 1'b0;
          @(posedge clk);
          if (pending_px.size() == 0)
            report_mismatch("directed read missing", 0, 1);
          else if ({pending_px[$].out_red, pending_px[$].out_green, pending_px[$].out_blue}
                   !== known_col[j])
            report_mismatch("directed read", pending_px[$].out_red, known_col[j][23:16]);
          hits = 1;
        end
      end
      if (hits == 0) send_request(rq);
      hits = 0;
    end
    drain_results();

    // Random traffic in three idling phases with register changes between.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_reg(lmfs_pkg::REG_BRIGHTNESS, 32'd255);
          write_reg(lmfs_pkg::REG_ROTATION, 32'd1);
          write_reg(lmfs_pkg::REG_MAX_CURR, 32'd0);
        end
        1: begin
          send_idle_pct = 46; recv_idle_pct = 18;
          write_reg(lmfs_pkg::REG_BRIGHTNESS, 32'd0);
          write_reg(lmfs_pkg::REG_ROTATION, 32'd2);
          write_reg(lmfs_pkg::REG_MAX_CURR, 32'd4095);
        end
        default: begin
          send_idle_pct = 0; recv_idle_pct = 0;
          write_reg(lmfs_pkg::REG_BRIGHTNESS, 32'($urandom_range(1, 254)));
          write_reg(lmfs_pkg::REG_ROTATION, 32'd3);
          write_reg(lmfs_pkg::REG_MAX_CURR, 32'($urandom_range(50, 900)));
        end
      endcase
      for (int n = 0; n < 114; n++) begin
        if (ph == 2 && n == 10) hold_cycles = 600;  // back up the input
        rq = random_request();
        send_request(rq);
      end
      drain_results();
    end

    $display("covered %0d requests: %0d read replies and %0d shown pixels checked",
             req_cnt, read_cnt, shown_cnt);
    $display("all four rotations, brightness 0/255 and current caps 0/4095 exercised");
    if (mismatch_cnt == 0 && pending_px.size() == 0) begin
      $display("[led_matrix_frame_scaler] OK");
    end else begin
      $display("[led_matrix_frame_scaler] ERROR");
    end
    $finish;
  end

endmodule
